// File: src/lrc_pkg.sv
// Shared types and constants for the fully associative LRU cache.
// No dependencies; imported by lrc_store, the top level, the checker and the testbench.
`default_nettype none

package lrc_pkg;

  localparam int CFG_W   = 5;   // capacity register width
  localparam int OP_W    = 2;   // opcode width
  localparam int OCC_W   = 5;   // occupancy field width
  localparam int STAMP_W = 64;  // access stamp width

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_PROBE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic entry_we;  // key and value together
    logic stamp_we;
  } lrc_wr_t;

endpackage

`default_nettype wire

// File: src/lrc_store.sv
// Slot storage: key/value memory and stamp memory, one write and one read port,
// read data registered. Depends on lrc_pkg.
`default_nettype none

module lrc_store #(
  parameter int SLOTS      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 16,
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                        clk_i,
  input  wire lrc_pkg::lrc_wr_t            wr_i,
  input  wire logic [IDX_W-1:0]            waddr_i,
  input  wire logic [KEY_BITS-1:0]         wkey_i,
  input  wire logic [VALUE_BITS-1:0]       wval_i,
  input  wire logic [lrc_pkg::STAMP_W-1:0] wstamp_i,
  input  wire logic [IDX_W-1:0]            raddr_i,
  output logic      [KEY_BITS-1:0]         rkey_o,
  output logic      [VALUE_BITS-1:0]       rval_o,
  output logic      [lrc_pkg::STAMP_W-1:0] rstamp_o
);
  import lrc_pkg::*;

  logic [VALUE_BITS+KEY_BITS-1:0] entry_mem [SLOTS];
  logic [STAMP_W-1:0]             stamp_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.entry_we) begin
      entry_mem[waddr_i] <= {wval_i, wkey_i};
    end
    if (wr_i.stamp_we) begin
      stamp_mem[waddr_i] <= wstamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    {rval_o, rkey_o} <= entry_mem[raddr_i];
    rstamp_o         <= stamp_mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/lru_associative_cache.sv
// Top level of the fully associative cache with timestamp LRU replacement.
// Depends on lrc_pkg and lrc_store.
//
// Usage:
//   Input stream: tuser = opcode (lookup, insert, clear, probe), tdata holds
//   key and value_in. Output stream: one result transfer per input transfer,
//   tdata holds hit, value_out, evicted and occupancy.
//   cfg_we_i/cfg_wdata_i write the active slot count (0 acts as 1, values
//   above SLOTS act as SLOTS); slots at or above the limit are emptied.
//   Write it only while no operation is in flight.
// Timing:
//   Each lookup, insert or probe scans the active slots one per cycle through
//   the read port of the slot memories, then decides and writes back; a clear
//   skips the scan. A new item is accepted only after the last one has passed
//   its result to the result register.
// Reset:
//   All slots empty, access clock zero, capacity SLOTS. No clearing pass.
// Stall:
//   A new item is taken while a result waits; a finished item holds in its
//   write-back step until the result register is free.
`default_nettype none

module lru_associative_cache #(
  parameter int SLOTS      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 16,
  localparam int IN_W      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((VALUE_BITS + lrc_pkg::OCC_W + 2 + 7) / 8) * 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [lrc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [IN_W-1:0]          s_axis_tdata,  // key, value_in
  input  wire logic [lrc_pkg::OP_W-1:0] s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic      [OUT_W-1:0]         m_axis_tdata   // hit, value_out, evicted, occupancy
);
  import lrc_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIM_W = $clog2(SLOTS + 1);

  state_e st_q, st_d;

  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [LIM_W-1:0]      lim_q;
  logic [SLOTS-1:0]      v_q;
  logic [SLOTS-1:0]      v_d;
  logic [IDX_W-1:0]      ptr_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [STAMP_W-1:0]    clk_q;

  logic                  found_q;
  logic [IDX_W-1:0]      hidx_q;
  logic [VALUE_BITS-1:0] hval_q;
  logic [LIM_W-1:0]      cnt_q;
  logic                  vic_found_q;
  logic [IDX_W-1:0]      vic_idx_q;
  logic [STAMP_W-1:0]    vic_stamp_q;
  logic                  emp_found_q;
  logic [IDX_W-1:0]      emp_idx_q;

  logic                  ov_q;
  logic                  ohit_q;
  logic [VALUE_BITS-1:0] oval_q;
  logic                  oev_q;
  logic [OCC_W-1:0]      oocc_q;

  logic                  accept;
  logic                  fire;
  logic                  scan_last;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_val;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic [STAMP_W-1:0]    rstamp;
  logic                  sv;
  logic                  mt;
  logic [31:0]           cfg_ext;
  logic [31:0]           cfg_lim;

  lrc_wr_t               wr;
  logic [IDX_W-1:0]      waddr;
  logic                  full;
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_val;
  logic                  res_ev;
  logic [LIM_W-1:0]      res_occ;
  logic                  set_v;

  assign in_key = s_axis_tdata[KEY_BITS-1:0];
  assign in_val = s_axis_tdata[KEY_BITS +: VALUE_BITS];

  assign cfg_ext = 32'(cfg_wdata_i);
  assign cfg_lim = (cfg_ext == 32'd0) ? 32'd1 :
                   (cfg_ext > 32'(SLOTS)) ? 32'(SLOTS) : cfg_ext;

  assign scan_last = (32'(ptr_q) == 32'(lim_q) - 32'd1);
  assign sv        = v_q[rd_idx_q];
  assign mt        = sv && (rkey == key_q);
  assign full      = (cnt_q == lim_q);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d = (op_e'(s_axis_tuser) == OP_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: st_d = ST_DONE;
      ST_DONE: begin
        if (fire) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs and write-back decision
  always_comb begin
    s_axis_tready = (st_q == ST_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    fire          = (st_q == ST_DONE) && (!ov_q || m_axis_tready);
    wr            = '0;
    waddr         = hidx_q;
    set_v         = 1'b0;
    res_hit       = 1'b0;
    res_val       = '0;
    res_ev        = 1'b0;
    res_occ       = cnt_q;
    case (op_q)
      OP_CLEAR: begin
        res_occ = '0;
      end
      OP_LOOKUP: begin
        res_hit     = found_q;
        wr.stamp_we = fire && found_q;
        if (found_q) begin
          res_val = hval_q;
        end
      end
      OP_PROBE: begin
        res_hit = found_q;
      end
      OP_INSERT: begin
        if (found_q) begin
          res_hit     = 1'b1;
          wr.stamp_we = fire;
        end else begin
          waddr       = full ? vic_idx_q : emp_idx_q;
          res_ev      = full;
          res_occ     = full ? cnt_q : cnt_q + 1'b1;
          wr.entry_we = fire;
          wr.stamp_we = fire;
          set_v       = fire;
        end
      end
      default: ;
    endcase
  end

  // valid bits: clear, fill, capacity trim
  always_comb begin
    v_d = v_q;
    if (fire && (op_q == OP_CLEAR)) begin
      v_d = '0;
    end else if (set_v) begin
      v_d[waddr] = 1'b1;
    end
    if (cfg_we_i) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (32'(i) >= cfg_lim) begin
          v_d[i] = 1'b0;
        end
      end
    end
  end

  lrc_store #(
    .SLOTS     (SLOTS),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .waddr_i (waddr),
    .wkey_i  (key_q),
    .wval_i  (val_q),
    .wstamp_i(clk_q + 64'd1),
    .raddr_i (ptr_q),
    .rkey_o  (rkey),
    .rval_o  (rval),
    .rstamp_o(rstamp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      lim_q    <= LIM_W'(SLOTS);
      v_q      <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      clk_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      rd_vld_q <= (st_q == ST_SCAN);
      v_q      <= v_d;
      if (accept) begin
        ptr_q <= '0;
      end else if (st_q == ST_SCAN) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (wr.stamp_we) begin
        clk_q <= clk_q + 64'd1;
      end
      if (cfg_we_i) begin
        lim_q <= LIM_W'(cfg_lim);
      end
      if (fire) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // item registers, scan accumulators, result register
  always_ff @(posedge clk_i) begin
    rd_idx_q <= ptr_q;
    if (accept) begin
      op_q        <= op_e'(s_axis_tuser);
      key_q       <= in_key;
      val_q       <= in_val;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      vic_found_q <= 1'b0;
      emp_found_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (mt && !found_q) begin
        found_q <= 1'b1;
        hidx_q  <= rd_idx_q;
        hval_q  <= rval;
      end
      if (sv) begin
        cnt_q <= cnt_q + 1'b1;
        if (!vic_found_q || (rstamp < vic_stamp_q)) begin
          vic_found_q <= 1'b1;
          vic_idx_q   <= rd_idx_q;
          vic_stamp_q <= rstamp;
        end
      end else if (!emp_found_q) begin
        emp_found_q <= 1'b1;
        emp_idx_q   <= rd_idx_q;
      end
    end
    if (fire) begin
      ohit_q <= res_hit;
      oval_q <= res_val;
      oev_q  <= res_ev;
      oocc_q <= OCC_W'(res_occ);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_W'({oocc_q, oev_q, oval_q, ohit_q});

endmodule

`default_nettype wire

// File: src/lrc_checker.sv
// Port-level checks on the result stream of lru_associative_cache, with the
// bind that attaches them. Depends on lrc_pkg.
`default_nettype none

module lrc_checker #(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 16,
  parameter int OUT_W      = 24
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);
  import lrc_pkg::*;

  logic                  r_hit;
  logic [VALUE_BITS-1:0] r_val;
  logic                  r_ev;
  logic [OCC_W-1:0]      r_occ;

  assign r_hit = m_axis_tdata[0];
  assign r_val = m_axis_tdata[VALUE_BITS:1];
  assign r_ev  = m_axis_tdata[VALUE_BITS+1];
  assign r_occ = m_axis_tdata[VALUE_BITS+OCC_W+1:VALUE_BITS+2];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_hit_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(r_hit && r_ev))
    else $error("eviction reported on a hit");

  a_val_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (r_val != '0) |-> r_hit)
    else $error("value returned without a hit");

  a_ev_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r_ev |-> (r_occ != '0) || (SLOTS >= 32))
    else $error("eviction with empty cache");

endmodule

bind lru_associative_cache lrc_checker #(
  .SLOTS     (SLOTS),
  .VALUE_BITS(VALUE_BITS),
  .OUT_W     (OUT_W)
) u_lrc_checker (.*);

`default_nettype wire

// File: tb/lru_associative_cache_tb.sv
// Testbench for lru_associative_cache: directed and random lookup, insert, probe and clear
// traffic, checked against a shadow of the slot array with timestamp LRU replacement.
// Depends on lrc_pkg and the RTL of the cache.
`default_nettype none

module lru_associative_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrc_pkg::*;

  localparam int NUM_SLOTS  = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 16;
  localparam int REQ_W      = 48;
  localparam int RESP_W     = 24;
  localparam int SETTLE     = 24;
  localparam int MAX_CYCLES = 600000;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value_out;
    logic             evicted;
    logic [OCC_W-1:0] occupancy;
  } cache_resp_t;

  class lru_cache_shadow;
    bit                 slot_valid [NUM_SLOTS];
    logic [KEY_W-1:0]   slot_key   [NUM_SLOTS];
    logic [VAL_W-1:0]   slot_value [NUM_SLOTS];
    logic [STAMP_W-1:0] slot_stamp [NUM_SLOTS];
    logic [STAMP_W-1:0] access_clock;
    int unsigned        capacity;
    cache_resp_t        pending_resp [$];
    int unsigned        mismatches, requests, results, hits, evictions;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      access_clock = '0;
      capacity     = NUM_SLOTS;
    endfunction

    function void load_limit(logic [CFG_W-1:0] wdata);
      capacity = (wdata == '0) ? 32'd1 :
                 (32'(wdata) > NUM_SLOTS) ? NUM_SLOTS : 32'(wdata);
      for (int i = capacity; i < NUM_SLOTS; i++) slot_valid[i] = 1'b0;
    endfunction

    function void note_request(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      cache_resp_t r;
      int          idx, victim, occ;
      bit          placed;
      r   = '0;
      idx = -1;
      for (int i = 0; i < capacity; i++)
        if (idx < 0 && slot_valid[i] && slot_key[i] == key) idx = i;
      case (op)
        OP_CLEAR: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        end
        OP_LOOKUP, OP_PROBE: begin
          if (idx >= 0) begin
            r.hit = 1'b1;
            if (op == OP_LOOKUP) begin
              access_clock     += 1;
              slot_stamp[idx]   = access_clock;
              r.value_out       = slot_value[idx];
            end
          end
        end
        OP_INSERT: begin
          if (idx >= 0) begin
            r.hit            = 1'b1;
            access_clock    += 1;
            slot_stamp[idx]  = access_clock;
          end else begin
            occ = 0;
            for (int i = 0; i < capacity; i++) if (slot_valid[i]) occ++;
            if (occ >= capacity) begin
              // oldest stamp loses, lowest slot loses a tie
              victim = -1;
              for (int i = 0; i < capacity; i++)
                if (slot_valid[i] && (victim < 0 || slot_stamp[i] < slot_stamp[victim]))
                  victim = i;
              if (victim >= 0) begin
                slot_valid[victim] = 1'b0;
                r.evicted          = 1'b1;
              end
            end
            placed = 1'b0;
            for (int i = 0; i < capacity; i++) begin
              if (!placed && !slot_valid[i]) begin
                access_clock  += 1;
                slot_valid[i]  = 1'b1;
                slot_key[i]    = key;
                slot_value[i]  = val;
                slot_stamp[i]  = access_clock;
                placed         = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      occ = 0;
      foreach (slot_valid[i]) if (slot_valid[i]) occ++;
      r.occupancy = OCC_W'(occ);
      pending_resp.push_back(r);
      requests++;
    endfunction

    function void check_result(logic [RESP_W-1:0] tdata);
      cache_resp_t want;
      logic             got_hit, got_ev;
      logic [VAL_W-1:0] got_val;
      logic [OCC_W-1:0] got_occ;
      got_hit = tdata[0];
      got_val = tdata[16:1];
      got_ev  = tdata[17];
      got_occ = tdata[22:18];
      results++;
      if (pending_resp.size() == 0) begin
        $error("result transfer with no request outstanding: tdata %h", tdata);
        mismatches++;
        return;
      end
      want = pending_resp.pop_front();
      if (want.hit) hits++;
      if (want.evicted) evictions++;
      if (got_hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got_hit);
        mismatches++;
      end
      if (got_val !== want.value_out) begin
        $error("value_out: expected %h, got %h", want.value_out, got_val);
        mismatches++;
      end
      if (got_ev !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got_ev);
        mismatches++;
      end
      if (got_occ !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got_occ);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               s_tvalid = 1'b0;
  logic [REQ_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]    s_tuser = '0;
  logic               m_tready = 1'b0;
  logic               s_axis_tready;
  logic               m_axis_tvalid;
  logic [RESP_W-1:0]  m_axis_tdata;

  lru_cache_shadow    shadow = new();
  int unsigned        cycles = 0;
  int unsigned        burst_left = 0;
  int unsigned        max_gap = 4;
  int unsigned        settings = 1;
  logic [KEY_W-1:0]   key_pool [$];

  lru_associative_cache i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side: check, then pick the next stall pattern
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && m_axis_tvalid && m_tready) shadow.check_result(m_axis_tdata);
    case ((cycles / 173) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 5) == 0);
      default: m_tready <= (cycles[2:0] != 3'd0);
    endcase
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_req(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {val, key};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_request(op, key, val);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (shadow.pending_resp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] wdata);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= wdata;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    shadow.load_limit(wdata);
    settings++;
  endtask

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 42) return OP_INSERT;
    if (r < 72) return OP_LOOKUP;
    if (r < 97) return OP_PROBE;
    return OP_CLEAR;
  endfunction

  // keys mostly from a pool a bit larger than the capacity, so hits and evictions both occur
  task automatic run_phase(logic [CFG_W-1:0] wdata, int unsigned count, int unsigned gap_max);
    int unsigned cap, pool_n;
    logic [KEY_W-1:0] key;
    write_capacity(wdata);
    max_gap = gap_max;
    cap     = shadow.capacity;
    pool_n  = cap + $urandom_range(1, cap + 4);
    key_pool.delete();
    repeat (pool_n) key_pool.push_back($urandom);
    for (int n = 0; n < count; n++) begin
      key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
      send_req(pick_op(), key, 16'($urandom_range(0, 16'hffff)));
      if (n == count / 2 && wdata == 5'd4) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cache, field extremes, refresh on present key, clear
    max_gap = 2;
    send_req(OP_LOOKUP, 32'hffff_ffff, 16'h0000);
    send_req(OP_PROBE,  32'h0000_0000, 16'hffff);
    send_req(OP_INSERT, 32'h0000_0000, 16'hffff);
    send_req(OP_INSERT, 32'hffff_ffff, 16'h0000);
    send_req(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    send_req(OP_PROBE,  32'hffff_ffff, 16'h0000);
    send_req(OP_INSERT, 32'h0000_0000, 16'h1234);
    send_req(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    send_req(OP_CLEAR,  32'h0000_0000, 16'h0000);
    send_req(OP_LOOKUP, 32'h0000_0000, 16'h0000);

    // capacity zero acts as one
    write_capacity(5'd0);
    send_req(OP_INSERT, 32'ha5a5_a5a5, 16'h5a5a);
    send_req(OP_INSERT, 32'h5a5a_5a5a, 16'ha5a5);
    send_req(OP_LOOKUP, 32'h5a5a_5a5a, 16'h0000);

    // LRU pick: touching the first key makes the second the victim
    write_capacity(5'd2);
    send_req(OP_INSERT, 32'h1111_1111, 16'h0001);
    send_req(OP_INSERT, 32'h2222_2222, 16'h0002);
    send_req(OP_LOOKUP, 32'h1111_1111, 16'h0000);
    send_req(OP_INSERT, 32'h3333_3333, 16'h0003);
    send_req(OP_PROBE,  32'h2222_2222, 16'h0000);
    send_req(OP_PROBE,  32'h1111_1111, 16'h0000);
    send_req(OP_INSERT, 32'h3333_3333, 16'hbeef);
    send_req(OP_INSERT, 32'h4444_4444, 16'h0004);
    send_req(OP_LOOKUP, 32'h3333_3333, 16'h0000);

    run_phase(5'd16, 240, 6);
    run_phase(5'd1,  200, 3);
    run_phase(5'd31, 240, 0);
    run_phase(5'd17, 220, 8);
    run_phase(5'd4,  240, 4);
    run_phase(5'd8,  240, 0);
    run_phase(5'($urandom_range(3, 15)), 230, 5);
    run_phase(5'd16, 240, 2);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("Ran %0d requests across %0d capacity settings in %0d cycles.",
             shadow.requests, settings, cycles);
    $display("Saw %0d results with %0d hits and %0d evictions.",
             shadow.results, shadow.hits, shadow.evictions);
    if (shadow.mismatches == 0 && shadow.pending_resp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
